// ----- src/cfa_pkg.sv -----
package cfa_pkg;

  localparam int ADDR_W  = 20;
  localparam int LEN_W   = 21;
  localparam int OWNER_W = 16;
  localparam int NFREE_W = 7;

  localparam int DEF_MEM_BYTES  = 1048576;
  localparam int DEF_MAX_BLOCKS = 64;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_NO_OWNR = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Placement policies.
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    logic               is_free;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic    pop;
    logic    push;
    entry_t  data;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [OWNER_W-1:0] process_id;
    logic [LEN_W-1:0]   request_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  address;
    logic [LEN_W-1:0]   total_free;
    logic [LEN_W-1:0]   largest_free;
    logic [NFREE_W-1:0] free_blocks;
    logic [LEN_W-1:0]   allocated_total;
    logic [LEN_W-1:0]   external_fragment;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_INSERT,
    S_FREE,
    S_FREE_TAIL,
    S_REPORT,
    S_DONE
  } state_t;

endpackage

// ----- src/contiguous_fit_allocator.sv -----
// Contiguous fit allocator: an address-ordered table of memory blocks kept
// in a row of cells that shifts toward the head cell.
// The input channel (in_valid, in_stall, in_data) carries allocate, free and
// report commands; the result channel (out_valid, out_stall, out_data)
// returns one result per command. cfg_wr_en/cfg_wr_data set the fit policy.
// One command is worked on at a time; in_stall is high from the transfer
// until its result has been taken. An allocate scans the table and, with
// a fitting block and room left, applies it in a second pass and inserts
// the remainder of a split block; a free makes one pass and pushes the last
// merged entry; a report makes one pass. Each pass moves the table, at most
// MAX_BLOCKS entries, once through the head cell, one entry per cycle except
// while a remainder is inserted. A zero-size allocate or unused opcode
// skips the passes; after each result transfer the block goes idle before
// the next input transfer. Reset (synchronous, rst_n low) leaves one free
// block covering MEM_BYTES and first-fit policy. While the receiver holds
// out_stall, the result stays on out_data and no new command is taken.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int MEM_BYTES  = DEF_MEM_BYTES,
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] wptr;
  entry_t           cells [MAX_BLOCKS];

  cfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (cells[0]),
    .ctl         (ctl),
    .wptr        (wptr)
  );

  // Row of table cells; on a pop each takes the entry to its right, if any.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    cfa_cell #(
      .IDX       (i),
      .IDX_W     (IDX_W),
      .MEM_BYTES (MEM_BYTES)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .wptr  (wptr),
      .right ((i == MAX_BLOCKS - 1) ? cells[i] : cells[(i + 1) % MAX_BLOCKS]),
      .entry (cells[i])
    );
  end

endmodule

// ----- src/cfa_cell.sv -----
module cfa_cell
  import cfa_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDX_W      = 6,
  parameter int MEM_BYTES  = DEF_MEM_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] wptr,
  input  entry_t           right,
  output entry_t           entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Shift toward the head on a pop; take the pushed entry at the write slot.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = right;
    end
    if (ctl.push && (wptr == IDX_W'(IDX))) begin
      entry_nxt = ctl.data;
    end
  end

  // The head cell starts as one free block spanning all memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.start   <= '0;
      entry_r.len     <= (IDX == 0) ? LEN_W'(MEM_BYTES) : '0;
      entry_r.is_free <= (IDX == 0);
      entry_r.owner   <= entry_nxt.owner;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// ----- src/cfa_ctrl.sv -----
module cfa_ctrl
  import cfa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  entry_t           head,
  output cell_ctl_t        ctl,
  output logic [IDX_W-1:0] wptr
);

  state_t             state_r, state_nxt;
  logic [1:0]         policy_r;
  in_item_t           cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]   ncnt_r, ncnt_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic               found_r, found_nxt;
  logic               split_r, split_nxt;
  entry_t             acc_r, acc_nxt;
  logic               acc_v_r, acc_v_nxt;
  logic [LEN_W-1:0]   tot_r, tot_nxt;
  logic [LEN_W-1:0]   big_r, big_nxt;
  logic [LEN_W-1:0]   used_r, used_nxt;
  logic [NFREE_W-1:0] nfree_r, nfree_nxt;
  out_item_t          out_r, out_nxt;
  entry_t             hmod;
  logic               last;
  logic               fits;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_r;
  assign last      = (step_r == cnt_r - CNT_W'(1));
  assign fits      = head.is_free && (head.len >= cmd_r.request_size);

  // Head entry with the owner's used block released.
  always_comb begin
    hmod = head;
    if (!head.is_free && (head.owner == cmd_r.process_id)) begin
      hmod.is_free = 1'b1;
      hmod.owner   = '0;
    end
  end

  // Sequencer: every pass moves the table through the cell row once.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ncnt_nxt  = ncnt_r;
    pick_nxt  = pick_r;
    plen_nxt  = plen_r;
    found_nxt = found_r;
    split_nxt = split_r;
    acc_nxt   = acc_r;
    acc_v_nxt = acc_v_r;
    tot_nxt   = tot_r;
    big_nxt   = big_r;
    used_nxt  = used_r;
    nfree_nxt = nfree_r;
    out_nxt   = out_r;
    ctl.pop   = 1'b0;
    ctl.push  = 1'b0;
    ctl.data  = head;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          step_nxt  = '0;
          ncnt_nxt  = '0;
          found_nxt = 1'b0;
          acc_v_nxt = 1'b0;
          tot_nxt   = '0;
          big_nxt   = '0;
          used_nxt  = '0;
          nfree_nxt = '0;
          out_nxt   = '0;
          case (in_data.opcode)
            OP_ALLOC: begin
              if (in_data.request_size == '0) begin
                out_nxt.status = ST_NO_FIT;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_FREE:   state_nxt = S_FREE;
            OP_REPORT: state_nxt = S_REPORT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        // Rotate the table and keep the candidate block.
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
        if (fits) begin
          if (!found_r) begin
            found_nxt = 1'b1;
            pick_nxt  = step_r[IDX_W-1:0];
            plen_nxt  = head.len;
          end else if ((policy_r == POL_BEST) && (head.len < plen_r)) begin
            pick_nxt = step_r[IDX_W-1:0];
            plen_nxt = head.len;
          end else if ((policy_r == POL_WORST) && (head.len > plen_r)) begin
            pick_nxt = step_r[IDX_W-1:0];
            plen_nxt = head.len;
          end
        end
        step_nxt = step_r + CNT_W'(1);
        if (last) begin
          step_nxt  = '0;
          split_nxt = plen_nxt > cmd_r.request_size;
          if (!found_nxt) begin
            out_nxt.status = ST_NO_FIT;
            state_nxt      = S_DONE;
          end else if (split_nxt && (cnt_r >= CNT_W'(MAX_BLOCKS))) begin
            out_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(pick_r)) begin
          ctl.data.is_free = 1'b0;
          ctl.data.owner   = cmd_r.process_id;
          out_nxt.address  = head.start;
          if (split_r) begin
            ctl.data.len  = cmd_r.request_size;
            acc_nxt.start = head.start + cmd_r.request_size[ADDR_W-1:0];
            acc_nxt.len   = head.len - cmd_r.request_size;
            acc_nxt.is_free = 1'b1;
            acc_nxt.owner = '0;
            state_nxt     = S_INSERT;
          end else if (last) begin
            state_nxt = S_DONE;
          end
        end else if (last) begin
          cnt_nxt   = cnt_r + CNT_W'(split_r);
          state_nxt = S_DONE;
        end
      end
      S_INSERT: begin
        // Push the split remainder right behind the allocated block.
        ctl.push = 1'b1;
        ctl.data = acc_r;
        if (step_r == cnt_r) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_FREE: begin
        // Release the owner's blocks and merge free runs in one pass.
        ctl.pop  = 1'b1;
        ctl.data = acc_r;
        step_nxt = step_r + CNT_W'(1);
        if (hmod.is_free && !head.is_free) begin
          found_nxt = 1'b1;
        end
        if (!acc_v_r) begin
          acc_nxt   = hmod;
          acc_v_nxt = 1'b1;
        end else if (acc_r.is_free && hmod.is_free) begin
          acc_nxt.len = acc_r.len + hmod.len;
        end else begin
          ctl.push = 1'b1;
          acc_nxt  = hmod;
          ncnt_nxt = ncnt_r + CNT_W'(1);
        end
        if (last) begin
          state_nxt = S_FREE_TAIL;
        end
      end
      S_FREE_TAIL: begin
        ctl.push       = 1'b1;
        ctl.data       = acc_r;
        cnt_nxt        = ncnt_r + CNT_W'(1);
        out_nxt.status = found_r ? ST_DONE : ST_NO_OWNR;
        state_nxt      = S_DONE;
      end
      S_REPORT: begin
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
        step_nxt = step_r + CNT_W'(1);
        if (head.is_free) begin
          tot_nxt   = tot_r + head.len;
          nfree_nxt = nfree_r + NFREE_W'(1);
          if (head.len > big_r) begin
            big_nxt = head.len;
          end
        end else begin
          used_nxt = used_r + head.len;
        end
        if (last) begin
          out_nxt.total_free        = tot_nxt;
          out_nxt.largest_free      = big_nxt;
          out_nxt.free_blocks       = nfree_nxt;
          out_nxt.allocated_total   = used_nxt;
          out_nxt.external_fragment = tot_nxt - big_nxt;
          state_nxt                 = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Table occupancy and the slot that a push lands in.
  assign occ_nxt = occ_r + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
  assign wptr    = IDX_W'(occ_r - CNT_W'(ctl.pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      policy_r <= '0;
      cnt_r    <= CNT_W'(1);
      occ_r    <= CNT_W'(1);
      acc_v_r  <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      occ_r   <= occ_nxt;
      acc_v_r <= acc_v_nxt;
      found_r <= found_nxt;
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    step_r  <= step_nxt;
    ncnt_r  <= ncnt_nxt;
    pick_r  <= pick_nxt;
    plen_r  <= plen_nxt;
    split_r <= split_nxt;
    acc_r   <= acc_nxt;
    tot_r   <= tot_nxt;
    big_r   <= big_nxt;
    used_r  <= used_nxt;
    nfree_r <= nfree_nxt;
    out_r   <= out_nxt;
  end

endmodule
